// ----- sv/mmtp_pkg.sv -----
// mmtp_pkg: types, widths and codes shared by the thread picker modules
// no dependencies

package mmtp_pkg;

  localparam int unsigned MAX_THREADS = 16;
  localparam int unsigned TICKET_BITS = 16;

  localparam int unsigned IDX_W   = $clog2(MAX_THREADS);
  localparam int unsigned CNT_W   = $clog2(MAX_THREADS + 1);
  localparam int unsigned TOTAL_W = TICKET_BITS + IDX_W;
  localparam int unsigned DIVS_W  = TOTAL_W + 1;
  localparam int unsigned PRI_W   = 8;
  localparam int unsigned RAND_W  = 32;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned TC_W    = 5;
  localparam int unsigned N_W     = (TC_W > CNT_W) ? TC_W : CNT_W;
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = TC_W;

  localparam logic [TICKET_BITS-1:0] TICKET_MAX = '1;
  localparam logic [TC_W-1:0]        TC_RESET   = 5'd16;

  localparam logic [CFG_ADDR_W-1:0] REG_SCHED_MODE   = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_THREAD_COUNT = 1'd1;

  localparam logic OP_PICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_RR  = 2'd0,
    MODE_LOT = 2'd1,
    MODE_PRI = 2'd2
  } mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_WR_UPD,
    ST_DIV,
    ST_LOT_WALK,
    ST_PRI_WALK,
    ST_MOD,
    ST_SEEK
  } state_e;

  typedef struct packed {
    logic                   opcode;
    logic [IDX_W-1:0]       entry_index;
    logic [PRI_W-1:0]       entry_priority;
    logic [TICKET_BITS-1:0] entry_tickets;
    logic                   entry_alive;
    logic [RAND_W-1:0]      random_word;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0] chosen_thread;
    logic             chosen_valid;
  } result_t;

  typedef struct packed {
    logic [PRI_W-1:0]       prio;
    logic [TICKET_BITS-1:0] tickets;
  } entry_t;

endpackage

// ----- sv/mmtp_ram.sv -----
// mmtp_ram: generic single write port, single read port ram with registered read
// no dependencies

module mmtp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/mmtp_divider.sv -----
// mmtp_divider: restoring divider giving the remainder, one quotient bit per cycle
// depends on mmtp_pkg

module mmtp_divider
  import mmtp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [RAND_W-1:0] dividend_i,
  input  logic [DIVS_W-1:0] divisor_i,
  output logic              done_o,
  output logic [DIVS_W-1:0] rem_o
);

  localparam int unsigned STEP_W = $clog2(RAND_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [RAND_W-1:0] dvd_q, dvd_d;
  logic [DIVS_W-1:0] dvs_q, dvs_d;
  logic [DIVS_W-1:0] rem_q, rem_d;
  logic [DIVS_W:0]   shifted;

  assign shifted = {rem_q, dvd_q[RAND_W-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = STEP_W'(RAND_W);
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = dvd_q << 1;
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d = DIVS_W'(shifted - {1'b0, dvs_q});
      end else begin
        rem_d = DIVS_W'(shifted);
      end
      cnt_d = cnt_q - STEP_W'(1);
      if (cnt_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ----- sv/multi_mode_thread_picker.sv -----
// multi_mode_thread_picker: thread table with round robin, lottery and priority picks
// depends on mmtp_pkg, mmtp_ram and mmtp_divider
//
// usage
//   an item is taken when start_i is high and busy_o is low; a write item loads one
//   table entry, a pick item selects the next thread in the mode held in the config
//   register. every item gives exactly one result on res_o, marked by done_o for a
//   single cycle; the receiver cannot stall, so each result must be taken as shown.
//   configuration is written through cfg_we_i/cfg_addr_i/cfg_wdata_i while idle.
//   a pick with nothing alive, or with an unused mode, ends straight from dispatch; a
//   write item reads the old entry and then updates it. the other picks take longer,
//   set by the sequential walk over the entry ram (one entry a cycle), the index wrap
//   by repeated subtraction, the second priority pass once all are served, and the
//   remainder unit for the lottery draw.
//   one item is in flight at a time; busy_o is low again in the cycle of done_o.
//   reset clears the table (entries read as zero until written), selects round
//   robin with sixteen threads and sets the current thread to zero.

module multi_mode_thread_picker
  import mmtp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  item_t                 in_i,
  output logic                  busy_o,
  output logic                  done_o,
  output result_t               res_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  state_e                 state_q, state_d;
  mode_e                  mode_q;
  logic [TC_W-1:0]        tc_q;
  item_t                  item_q, item_d;
  logic [IDX_W-1:0]       cur_q, cur_d;
  logic [CNT_W-1:0]       idx_q, idx_d;
  logic [TOTAL_W-1:0]     rest_q, rest_d;
  logic [IDX_W-1:0]       best_idx_q, best_idx_d;
  logic [PRI_W-1:0]       best_pri_q, best_pri_d;
  logic                   found_q, found_d;
  logic [TOTAL_W-1:0]     total_q, total_d;
  logic [MAX_THREADS-1:0] alive_q, alive_d;
  logic [MAX_THREADS-1:0] served_q, served_d;
  logic [MAX_THREADS-1:0] written_q, written_d;
  result_t                res_q, res_d;
  logic                   done_q, done_d;

  logic [N_W-1:0]         n_full;
  logic [CNT_W-1:0]       n;
  logic [MAX_THREADS-1:0] used_mask;
  logic                   any_alive;

  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  entry_t                 ram_wdata;
  logic [IDX_W-1:0]       rd_addr;
  entry_t                 rd_data;

  logic                   div_start;
  logic                   div_done;
  logic [DIVS_W-1:0]      div_rem;

  logic [IDX_W-1:0]       cur_idx;
  logic [CNT_W-1:0]       idx_inc;
  logic                   last;
  logic [TICKET_BITS-1:0] walk_tk;
  logic [PRI_W-1:0]       walk_pri;
  logic [TICKET_BITS-1:0] wr_old;
  logic                   cand;
  logic [IDX_W-1:0]       win;

  mmtp_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_THREADS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  mmtp_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (item_q.random_word),
    .divisor_i  (DIVS_W'(total_q) + DIVS_W'(1)),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // threads in use
  always_comb begin
    if (tc_q == '0) begin
      n_full = N_W'(1);
    end else if (N_W'(tc_q) > N_W'(MAX_THREADS)) begin
      n_full = N_W'(MAX_THREADS);
    end else begin
      n_full = N_W'(tc_q);
    end
    n = CNT_W'(n_full);
    for (int k = 0; k < MAX_THREADS; k++) begin
      used_mask[k] = (CNT_W'(k) < n);
    end
    any_alive = |(alive_q & used_mask);
  end

  assign cur_idx  = idx_q[IDX_W-1:0];
  assign idx_inc  = idx_q + CNT_W'(1);
  assign last     = (idx_inc == n);
  assign walk_tk  = written_q[cur_idx] ? rd_data.tickets : '0;
  assign walk_pri = written_q[cur_idx] ? rd_data.prio : '0;
  assign wr_old   = written_q[item_q.entry_index] ? rd_data.tickets : '0;
  assign cand     = alive_q[cur_idx] && !served_q[cur_idx] &&
                    (!found_q || (rd_data.prio > best_pri_q));
  assign win      = cand ? cur_idx : best_idx_q;

  always_comb begin
    state_d    = state_q;
    item_d     = item_q;
    cur_d      = cur_q;
    idx_d      = idx_q;
    rest_d     = rest_q;
    best_idx_d = best_idx_q;
    best_pri_d = best_pri_q;
    found_d    = found_q;
    total_d    = total_q;
    alive_d    = alive_q;
    served_d   = served_q;
    written_d  = written_q;
    res_d      = res_q;
    done_d     = 1'b0;
    rd_addr    = cur_idx;
    ram_we     = 1'b0;
    ram_waddr  = cur_idx;
    ram_wdata  = '0;
    div_start  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          item_d  = in_i;
          state_d = ST_DISPATCH;
        end
      end

      ST_DISPATCH: begin
        if (item_q.opcode == OP_WRITE) begin
          rd_addr = item_q.entry_index;
          state_d = ST_WR_UPD;
        end else if (!any_alive) begin
          res_d   = '{chosen_thread: cur_q, chosen_valid: 1'b0};
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          case (mode_q)
            MODE_RR: begin
              idx_d   = CNT_W'(cur_q) + CNT_W'(1);
              state_d = ST_MOD;
            end
            MODE_LOT: begin
              div_start = 1'b1;
              state_d   = ST_DIV;
            end
            MODE_PRI: begin
              rd_addr = '0;
              idx_d   = '0;
              found_d = 1'b0;
              state_d = ST_PRI_WALK;
            end
            default: begin
              res_d   = '{chosen_thread: cur_q, chosen_valid: 1'b0};
              done_d  = 1'b1;
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      ST_WR_UPD: begin
        total_d   = total_q - TOTAL_W'(wr_old) + TOTAL_W'(item_q.entry_tickets);
        ram_we    = 1'b1;
        ram_waddr = item_q.entry_index;
        ram_wdata = '{prio: item_q.entry_priority, tickets: item_q.entry_tickets};
        written_d[item_q.entry_index] = 1'b1;
        alive_d[item_q.entry_index]   = item_q.entry_alive;
        served_d[item_q.entry_index]  = 1'b0;
        res_d   = '{chosen_thread: cur_q, chosen_valid: 1'b0};
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end

      ST_DIV: begin
        if (div_done) begin
          rest_d  = TOTAL_W'(div_rem);
          idx_d   = '0;
          rd_addr = '0;
          state_d = ST_LOT_WALK;
        end
      end

      ST_LOT_WALK: begin
        rd_addr = IDX_W'(idx_inc);
        if (TOTAL_W'(walk_tk) >= rest_q) begin
          state_d = ST_SEEK;
        end else begin
          rest_d = rest_q - TOTAL_W'(walk_tk);
          if (walk_tk != TICKET_MAX) begin
            ram_we    = 1'b1;
            ram_wdata = '{prio: walk_pri, tickets: walk_tk + TICKET_BITS'(1)};
            written_d[cur_idx] = 1'b1;
            total_d = total_q + TOTAL_W'(1);
          end
          if (last) begin
            res_d   = '{chosen_thread: cur_q, chosen_valid: 1'b0};
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_inc;
          end
        end
      end

      ST_PRI_WALK: begin
        rd_addr = IDX_W'(idx_inc);
        if (last) begin
          if (cand || found_q) begin
            served_d[win] = 1'b1;
            cur_d   = win;
            res_d   = '{chosen_thread: win, chosen_valid: 1'b1};
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end else begin
            // everything served: start a fresh round
            served_d = served_q & ~used_mask;
            idx_d    = '0;
            found_d  = 1'b0;
            rd_addr  = '0;
          end
        end else begin
          if (cand) begin
            best_idx_d = cur_idx;
            best_pri_d = rd_data.prio;
            found_d    = 1'b1;
          end
          idx_d = idx_inc;
        end
      end

      ST_MOD: begin
        if (idx_q >= n) begin
          idx_d = idx_q - n;
        end else begin
          state_d = ST_SEEK;
        end
      end

      ST_SEEK: begin
        if (alive_q[cur_idx]) begin
          cur_d   = cur_idx;
          res_d   = '{chosen_thread: cur_idx, chosen_valid: 1'b1};
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          idx_d = last ? '0 : idx_inc;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cur_q     <= '0;
      total_q   <= '0;
      alive_q   <= '0;
      served_q  <= '0;
      written_q <= '0;
      done_q    <= 1'b0;
      found_q   <= 1'b0;
      idx_q     <= '0;
    end else begin
      state_q   <= state_d;
      cur_q     <= cur_d;
      total_q   <= total_d;
      alive_q   <= alive_d;
      served_q  <= served_d;
      written_q <= written_d;
      done_q    <= done_d;
      found_q   <= found_d;
      idx_q     <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    rest_q     <= rest_d;
    best_idx_q <= best_idx_d;
    best_pri_q <= best_pri_d;
    res_q      <= res_d;
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RR;
      tc_q   <= TC_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_SCHED_MODE:   mode_q <= mode_e'(cfg_wdata_i[MODE_W-1:0]);
        REG_THREAD_COUNT: tc_q   <= cfg_wdata_i[TC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe held for more than one cycle");

  a_done_on_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_q)
    else $error("item finished without a result transfer");

  a_valid_alive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && res_q.chosen_valid) |-> alive_q[res_q.chosen_thread])
    else $error("picked thread is not alive");

  a_draw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && div_done) |-> (div_rem <= DIVS_W'(total_q)))
    else $error("lottery draw beyond ticket total");

endmodule

// ----- verif/mmtp_pick_check.sv -----
// mmtp_pick_check: watches the item, result and config ports of the thread picker,
// predicts each chosen thread and compares it with the result in transfer order
// depends on mmtp_pkg
`timescale 1ns / 1ps

module mmtp_pick_check
  import mmtp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  item_t                 item_i,
  input  logic                  busy_i,
  input  logic                  done_i,
  input  result_t               res_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int                    pending_o,
  output int                    mismatches_o
);

  logic [MODE_W-1:0]      mode_q;
  logic [TC_W-1:0]        tcount_q;
  logic [IDX_W-1:0]       cur_thread;
  logic [MAX_THREADS-1:0] alive_q;
  logic [MAX_THREADS-1:0] served_q;
  logic [PRI_W-1:0]       prio_q    [MAX_THREADS];
  logic [TICKET_BITS-1:0] tickets_q [MAX_THREADS];
  logic [TOTAL_W-1:0]     ticket_sum;
  result_t                chosen_q  [$];
  int                     mismatches;

  function automatic int unsigned threads_in_use();
    int unsigned n;
    n = 32'(tcount_q);
    if (n == 0) n = 1;
    if (n > MAX_THREADS) n = MAX_THREADS;
    return n;
  endfunction

  function automatic int unsigned next_alive(int unsigned from, int unsigned n);
    int unsigned i;
    int unsigned k;
    i = from % n;
    for (k = 0; k < n; k++) begin
      if (alive_q[i]) return i;
      i = (i + 1) % n;
    end
    return from % n;
  endfunction

  function automatic int best_unserved(int unsigned n);
    int             best;
    logic [PRI_W-1:0] best_pri;
    int unsigned    i;
    best     = -1;
    best_pri = '0;
    for (i = 0; i < n; i++) begin
      if (alive_q[i] && !served_q[i] && (best < 0 || prio_q[i] > best_pri)) begin
        best     = i;
        best_pri = prio_q[i];
      end
    end
    return best;
  endfunction

  function automatic result_t schedule_item(item_t it);
    int unsigned     n;
    int unsigned     i;
    int              pick;
    logic            any_alive;
    logic            valid;
    logic            stop;
    longint          rest;
    longint unsigned rw;
    longint unsigned span;
    result_t         res;
    n         = threads_in_use();
    valid     = 1'b0;
    any_alive = 1'b0;
    if (it.opcode == OP_WRITE) begin
      ticket_sum = ticket_sum - TOTAL_W'(tickets_q[it.entry_index])
                 + TOTAL_W'(it.entry_tickets);
      tickets_q[it.entry_index] = it.entry_tickets;
      prio_q[it.entry_index]    = it.entry_priority;
      alive_q[it.entry_index]   = it.entry_alive;
      served_q[it.entry_index]  = 1'b0;
    end else begin
      for (i = 0; i < n; i++) begin
        if (alive_q[i]) any_alive = 1'b1;
      end
      if (any_alive) begin
        case (mode_q)
          MODE_RR: begin
            cur_thread = IDX_W'(next_alive(int'(cur_thread) + 1, n));
            valid      = 1'b1;
          end
          MODE_LOT: begin
            rw   = 64'(it.random_word);
            span = 64'(ticket_sum);
            span = span + 1;
            rest = longint'(rw % span);
            stop = 1'b0;
            for (i = 0; i < n && !stop; i++) begin
              rest = rest - longint'(tickets_q[i]);
              if (rest <= 0) begin
                cur_thread = IDX_W'(next_alive(i, n));
                valid      = 1'b1;
                stop       = 1'b1;
              end else if (tickets_q[i] != TICKET_MAX) begin
                tickets_q[i] = tickets_q[i] + TICKET_BITS'(1);
                ticket_sum   = ticket_sum + TOTAL_W'(1);
              end
            end
          end
          MODE_PRI: begin
            pick = best_unserved(n);
            if (pick < 0) begin
              for (i = 0; i < n; i++) served_q[i] = 1'b0;
              pick = best_unserved(n);
            end
            if (pick >= 0) begin
              cur_thread       = IDX_W'(pick);
              served_q[pick]   = 1'b1;
              valid            = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
    res.chosen_thread = cur_thread;
    res.chosen_valid  = valid;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      mode_q     = MODE_RR;
      tcount_q   = TC_RESET;
      cur_thread = '0;
      alive_q    = '0;
      served_q   = '0;
      ticket_sum = '0;
      for (int i = 0; i < MAX_THREADS; i++) begin
        prio_q[i]    = '0;
        tickets_q[i] = '0;
      end
      chosen_q.delete();
      mismatches    = 0;
      pending_o    <= 0;
      mismatches_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_addr_i == REG_SCHED_MODE) mode_q = cfg_wdata_i[MODE_W-1:0];
        else if (cfg_addr_i == REG_THREAD_COUNT) tcount_q = cfg_wdata_i[TC_W-1:0];
      end
      if (done_i) begin
        if (chosen_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result thread %0d valid %0b", $time,
                     res_i.chosen_thread, res_i.chosen_valid);
        end else begin
          want = chosen_q.pop_front();
          if (res_i.chosen_thread !== want.chosen_thread ||
              res_i.chosen_valid !== want.chosen_valid) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: expected thread %0d valid %0b, got thread %0d valid %0b",
                       $time, want.chosen_thread, want.chosen_valid,
                       res_i.chosen_thread, res_i.chosen_valid);
          end
        end
      end
      if (start_i && !busy_i) chosen_q.push_back(schedule_item(item_i));
      pending_o    <= chosen_q.size();
      mismatches_o <= mismatches;
    end
  end

endmodule

// ----- verif/tb_top.sv -----
// tb_top: drives write and pick items and config writes into the thread picker,
// with directed corner cases and random phases of sender idling
// depends on mmtp_pkg, multi_mode_thread_picker and mmtp_pick_check
`timescale 1ns / 1ps

module tb_top;
  import mmtp_pkg::*;

  localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
  localparam int SETTLE_CYCLES = 80;
  localparam int RANDOM_PHASES = 24;
  localparam int PHASE_ITEMS   = 77;

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  start_i     = 1'b0;
  item_t                 in_i        = '0;
  logic                  busy_o;
  logic                  done_o;
  result_t               res_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  int                    pending;
  int                    mismatches;
  int                    idle_pct    = 0;

  multi_mode_thread_picker DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .in_i        (in_i),
    .busy_o      (busy_o),
    .done_o      (done_o),
    .res_o       (res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  mmtp_pick_check pick_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .item_i       (in_i),
    .busy_i       (busy_o),
    .done_i       (done_o),
    .res_i        (res_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .pending_o    (pending),
    .mismatches_o (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic item_t make_pick(logic [RAND_W-1:0] rw);
    item_t it;
    it.opcode         = OP_PICK;
    it.entry_index    = IDX_W'($urandom_range(0, MAX_THREADS - 1));
    it.entry_priority = PRI_W'($urandom_range(0, 255));
    it.entry_tickets  = TICKET_BITS'($urandom_range(0, 65535));
    it.entry_alive    = 1'($urandom_range(0, 1));
    it.random_word    = rw;
    return it;
  endfunction

  function automatic item_t make_write(int unsigned idx, int unsigned pri,
                                       int unsigned tix, logic alive);
    item_t it;
    it                = make_pick($urandom);
    it.opcode         = OP_WRITE;
    it.entry_index    = IDX_W'(idx);
    it.entry_priority = PRI_W'(pri);
    it.entry_tickets  = TICKET_BITS'(tix);
    it.entry_alive    = alive;
    return it;
  endfunction

  function automatic item_t random_item();
    int unsigned pri;
    int unsigned tix;
    int unsigned r;
    if ($urandom_range(0, 99) >= 25) return make_pick($urandom);
    r = $urandom_range(0, 9);
    if (r == 0) pri = 0;
    else if (r == 1) pri = 255;
    else if (r < 5) pri = $urandom_range(0, 3);
    else pri = $urandom_range(0, 255);
    r = $urandom_range(0, 9);
    if (r == 0) tix = 0;
    else if (r == 1) tix = 65535;
    else if (r < 6) tix = $urandom_range(0, 20);
    else tix = $urandom_range(0, 65535);
    return make_write($urandom_range(0, MAX_THREADS - 1), pri, tix,
                      $urandom_range(0, 3) != 0);
  endfunction

  task automatic send_item(input item_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    in_i    <= it;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic settle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [MODE_W-1:0] mode_v, input logic [TC_W-1:0] count_v);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= REG_SCHED_MODE;
    cfg_wdata_i <= CFG_DATA_W'(mode_v);
    @(posedge clk_i);
    cfg_addr_i  <= REG_THREAD_COUNT;
    cfg_wdata_i <= CFG_DATA_W'(count_v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    logic [MODE_W-1:0] mode_v;
    logic [TC_W-1:0]   count_v;
    int unsigned       r;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table, then round robin wrapping over the extremes of the entry fields
    send_item(make_pick($urandom));
    send_item(make_write(0, 0, 0, 1'b1));
    send_item(make_write(MAX_THREADS - 1, 255, 65535, 1'b1));
    send_item(make_write(7, 255, 1, 1'b1));
    send_item(make_write(3, 100, 0, 1'b0));
    repeat (3) send_item(make_pick($urandom));

    // lottery: zero draw, top draw, draws past the tickets in use
    set_config(MODE_LOT, 5'd16);
    send_item(make_pick('0));
    send_item(make_pick('1));
    send_item(make_pick($urandom));
    set_config(MODE_LOT, 5'd4);
    repeat (2) send_item(make_pick(32'd65000));
    set_config(MODE_LOT, 5'd16);
    send_item(make_write(0, 0, 65535, 1'b1));
    send_item(make_pick(32'd131000));

    // priority with a tie and the served marks running out
    set_config(MODE_PRI, 5'd16);
    repeat (4) send_item(make_pick($urandom));

    set_config(MODE_NONE, 5'd0);
    send_item(make_pick($urandom));
    set_config(MODE_RR, 5'd0);
    send_item(make_pick($urandom));
    set_config(MODE_RR, 5'd31);
    send_item(make_pick($urandom));

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 4)
        0: idle_pct = 0;
        1: idle_pct = 79;
        2: idle_pct = 0;
        default: idle_pct = 15;
      endcase
      r = $urandom_range(0, 19);
      if (r == 0) mode_v = MODE_NONE;
      else mode_v = MODE_W'(r % 3);
      r = $urandom_range(0, 9);
      if (r == 0) count_v = TC_W'($urandom_range(17, 31));
      else if (r == 1) count_v = '0;
      else if (r < 5) count_v = TC_W'($urandom_range(1, 4));
      else count_v = TC_W'($urandom_range(1, 16));
      set_config(mode_v, count_v);
      for (int k = 0; k < PHASE_ITEMS; k++) send_item(random_item());
    end

    settle();
    if (mismatches == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
